### hdl/dlsc_pkg.sv
package dlsc_pkg;

  // Field widths of the two channels.
  localparam int CH_W  = 8;
  localparam int CLS_W = 3;
  localparam int REL_W = 3;
  localparam int ERR_W = 3;
  localparam int ANG_W = 2;

  typedef logic [CH_W-1:0]  char_t;
  typedef logic [CLS_W-1:0] cls_t;
  typedef logic [REL_W-1:0] rel_t;
  typedef logic [ERR_W-1:0] err_t;
  typedef logic [ANG_W-1:0] ang_t;

  // Position in the grammar.
  typedef enum logic [3:0] {
    PH_LIST_START  = 4'd0,
    PH_AFTER_COMMA = 4'd1,
    PH_AFTER_PIPE  = 4'd2,
    PH_NAME        = 4'd3,
    PH_OPEN        = 4'd4,
    PH_VERS_PRE    = 4'd5,
    PH_VERS        = 4'd6,
    PH_CLOSED      = 4'd7
  } phase_t;

  // Character classes.
  localparam cls_t CLS_NAME    = 3'd0;
  localparam cls_t CLS_REL     = 3'd1;
  localparam cls_t CLS_VERSION = 3'd2;
  localparam cls_t CLS_SPACE   = 3'd3;
  localparam cls_t CLS_DELIM   = 3'd4;
  localparam cls_t CLS_END     = 3'd5;

  // Relation codes.
  localparam rel_t REL_ANY = 3'd0;
  localparam rel_t REL_EQ  = 3'd1;
  localparam rel_t REL_LT  = 3'd2;
  localparam rel_t REL_GE  = 3'd3;
  localparam rel_t REL_LE  = 3'd4;
  localparam rel_t REL_GT  = 3'd5;

  // Error codes.
  localparam err_t ERR_NONE       = 3'd0;
  localparam err_t ERR_BAD_NAME   = 3'd1;
  localparam err_t ERR_NAME_EXP   = 3'd2;
  localparam err_t ERR_PAREN_EXP  = 3'd3;
  localparam err_t ERR_REL_EXP    = 3'd4;
  localparam err_t ERR_CLOSE_EXP  = 3'd5;
  localparam err_t ERR_END_EXP    = 3'd6;
  localparam err_t ERR_DEP_EXP    = 3'd7;

  // First byte of a two-byte relation.
  localparam ang_t ANG_NONE = 2'd0;
  localparam ang_t ANG_LT   = 2'd1;
  localparam ang_t ANG_GT   = 2'd2;

  // Characters of the grammar.
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_LPAR  = 8'h28;
  localparam char_t CH_RPAR  = 8'h29;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_PIPE  = 8'h7C;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_EQ    = 8'h3D;
  localparam char_t CH_LT    = 8'h3C;
  localparam char_t CH_GT    = 8'h3E;

  function automatic logic is_name_byte(input char_t c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                      CH_PLUS, CH_MINUS, CH_DOT});
  endfunction

  function automatic logic is_delim(input char_t c);
    return (c == CH_COMMA) || (c == CH_PIPE);
  endfunction

endpackage

### hdl/dlsc_if.sv
interface dlsc_in_if;
  logic                 valid;
  logic                 ready;
  dlsc_pkg::char_t      ch;
  logic                 is_end;

  modport source (output valid, output ch, output is_end, input ready);
  modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface dlsc_out_if;
  logic                 valid;
  logic                 ready;
  dlsc_pkg::cls_t       char_class;
  logic                 dep_start;
  logic                 group_start;
  dlsc_pkg::rel_t       relation_code;
  dlsc_pkg::err_t       error_code;
  logic                 list_done;

  modport source (output valid, output char_class, output dep_start, output group_start,
                  output relation_code, output error_code, output list_done,
                  input ready);
  modport sink   (input valid, input char_class, input dep_start, input group_start,
                  input relation_code, input error_code, input list_done,
                  output ready);
endinterface

### hdl/dependency_list_syntax_checker.sv
// Dependency list syntax checker. Each request on in_chan carries one byte of a
// comma-separated list of pipe-separated alternatives, "name [(rel version)]", or an end
// marker (is_end) that closes the list, reports the verdict on error_code with list_done
// set, and starts a fresh list. Every request produces exactly one result on out_chan,
// tagging the byte with its class, dependency and group starts and the relation in force;
// the first error of a list is sticky until the end marker. One request is taken per clock
// cycle unless out_chan stalls: the grammar state and the single result register are
// updated in the same cycle, and in_chan stays ready while the result register is empty
// or being drained, so the result is registered and the throughput is one byte per cycle.
module dependency_list_syntax_checker (
  input  logic       clk,
  input  logic       rst_n,
  dlsc_in_if.sink    in_chan,
  dlsc_out_if.source out_chan
);

  // Grammar state.
  dlsc_pkg::phase_t phase_r, phase_nxt;
  dlsc_pkg::err_t   err_r, err_nxt;
  dlsc_pkg::rel_t   rel_r, rel_nxt;
  dlsc_pkg::ang_t   ang_r, ang_nxt;
  logic             tss_r, tss_nxt;

  // Result register.
  logic             out_valid_r;
  dlsc_pkg::cls_t   cls_r, cls_nxt;
  logic             ds_r, ds_nxt;
  logic             gs_r, gs_nxt;
  dlsc_pkg::rel_t   res_rel_r, res_rel_nxt;
  dlsc_pkg::err_t   res_err_r, res_err_nxt;
  logic             done_r, done_nxt;

  logic             in_ready;
  logic             accept;

  // Working values of the decode.
  dlsc_pkg::cls_t   cls;
  dlsc_pkg::err_t   err;
  dlsc_pkg::rel_t   rel_pick;
  logic             ds, gs;
  logic             sp, dl, nb;

  // The result register can take a new result when it is empty or being read out.
  assign in_ready      = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.char_class    = cls_r;
  assign out_chan.dep_start     = ds_r;
  assign out_chan.group_start   = gs_r;
  assign out_chan.relation_code = res_rel_r;
  assign out_chan.error_code    = res_err_r;
  assign out_chan.list_done     = done_r;

  always_comb begin
    phase_nxt   = phase_r;
    err_nxt     = err_r;
    rel_nxt     = rel_r;
    ang_nxt     = ang_r;
    tss_nxt     = tss_r;
    cls         = dlsc_pkg::CLS_SPACE;
    err         = dlsc_pkg::ERR_NONE;
    ds          = 1'b0;
    gs          = 1'b0;
    rel_pick    = dlsc_pkg::REL_ANY;
    cls_nxt     = dlsc_pkg::CLS_NAME;
    ds_nxt      = 1'b0;
    gs_nxt      = 1'b0;
    res_rel_nxt = dlsc_pkg::REL_ANY;
    res_err_nxt = dlsc_pkg::ERR_NONE;
    done_nxt    = 1'b0;
    sp          = (in_chan.ch == dlsc_pkg::CH_SPACE);
    dl          = dlsc_pkg::is_delim(in_chan.ch);
    nb          = dlsc_pkg::is_name_byte(in_chan.ch);

    if (in_chan.is_end) begin
      // The verdict is the latched error or whatever stopping here leaves unfinished.
      res_err_nxt = err_r;
      if (err_r == dlsc_pkg::ERR_NONE) begin
        case (phase_r)
          dlsc_pkg::PH_LIST_START: begin
            res_err_nxt = tss_r ? dlsc_pkg::ERR_NAME_EXP : dlsc_pkg::ERR_NONE;
          end
          dlsc_pkg::PH_AFTER_COMMA, dlsc_pkg::PH_AFTER_PIPE: begin
            res_err_nxt = dlsc_pkg::ERR_DEP_EXP;
          end
          dlsc_pkg::PH_NAME: begin
            res_err_nxt = tss_r ? dlsc_pkg::ERR_PAREN_EXP : dlsc_pkg::ERR_NONE;
          end
          dlsc_pkg::PH_OPEN: begin
            res_err_nxt = dlsc_pkg::ERR_REL_EXP;
          end
          dlsc_pkg::PH_VERS_PRE, dlsc_pkg::PH_VERS: begin
            res_err_nxt = dlsc_pkg::ERR_CLOSE_EXP;
          end
          default: begin
            res_err_nxt = tss_r ? dlsc_pkg::ERR_END_EXP : dlsc_pkg::ERR_NONE;
          end
        endcase
      end
      cls_nxt   = dlsc_pkg::CLS_END;
      done_nxt  = 1'b1;
      phase_nxt = dlsc_pkg::PH_LIST_START;
      err_nxt   = dlsc_pkg::ERR_NONE;
      rel_nxt   = dlsc_pkg::REL_ANY;
      ang_nxt   = dlsc_pkg::ANG_NONE;
      tss_nxt   = 1'b0;
    end else if (err_r != dlsc_pkg::ERR_NONE) begin
      // Once an error is latched, every byte up to the end marker just repeats it.
      res_err_nxt = err_r;
    end else begin
      case (phase_r)
        dlsc_pkg::PH_LIST_START, dlsc_pkg::PH_AFTER_COMMA, dlsc_pkg::PH_AFTER_PIPE: begin
          if (phase_r == dlsc_pkg::PH_LIST_START && tss_r) begin
            // Leading spaces: nothing valid can follow them.
            if (!sp) begin
              err = dl ? dlsc_pkg::ERR_DEP_EXP : dlsc_pkg::ERR_NAME_EXP;
            end
          end else if (sp) begin
            if (phase_r == dlsc_pkg::PH_LIST_START) begin
              tss_nxt = 1'b1;
            end
          end else if (dl) begin
            err = dlsc_pkg::ERR_DEP_EXP;
          end else if (in_chan.ch == dlsc_pkg::CH_LPAR) begin
            err = dlsc_pkg::ERR_NAME_EXP;
          end else if (nb) begin
            gs        = (phase_r != dlsc_pkg::PH_AFTER_PIPE);
            ds        = 1'b1;
            cls       = dlsc_pkg::CLS_NAME;
            phase_nxt = dlsc_pkg::PH_NAME;
            tss_nxt   = 1'b0;
            rel_nxt   = dlsc_pkg::REL_ANY;
            ang_nxt   = dlsc_pkg::ANG_NONE;
          end else begin
            err = dlsc_pkg::ERR_BAD_NAME;
          end
        end
        dlsc_pkg::PH_NAME: begin
          if (sp) begin
            tss_nxt = 1'b1;
          end else if (in_chan.ch == dlsc_pkg::CH_LPAR) begin
            phase_nxt = dlsc_pkg::PH_OPEN;
            tss_nxt   = 1'b0;
          end else if (dl) begin
            cls = dlsc_pkg::CLS_DELIM;
          end else if (tss_r) begin
            err = dlsc_pkg::ERR_PAREN_EXP;
          end else if (nb) begin
            cls = dlsc_pkg::CLS_NAME;
          end else begin
            err = dlsc_pkg::ERR_BAD_NAME;
          end
        end
        dlsc_pkg::PH_OPEN: begin
          if (ang_r == dlsc_pkg::ANG_NONE) begin
            if (sp) begin
              cls = dlsc_pkg::CLS_SPACE;
            end else if (in_chan.ch == dlsc_pkg::CH_EQ) begin
              rel_nxt   = dlsc_pkg::REL_EQ;
              phase_nxt = dlsc_pkg::PH_VERS_PRE;
              cls       = dlsc_pkg::CLS_REL;
            end else if (in_chan.ch == dlsc_pkg::CH_LT) begin
              ang_nxt = dlsc_pkg::ANG_LT;
              cls     = dlsc_pkg::CLS_REL;
            end else if (in_chan.ch == dlsc_pkg::CH_GT) begin
              ang_nxt = dlsc_pkg::ANG_GT;
              cls     = dlsc_pkg::CLS_REL;
            end else begin
              err = dlsc_pkg::ERR_REL_EXP;
            end
          end else begin
            // Second byte of "<<", "<=", ">=" or ">>".
            if (ang_r == dlsc_pkg::ANG_LT) begin
              rel_pick = (in_chan.ch == dlsc_pkg::CH_LT) ? dlsc_pkg::REL_LT :
                         (in_chan.ch == dlsc_pkg::CH_EQ) ? dlsc_pkg::REL_LE :
                                                           dlsc_pkg::REL_ANY;
            end else begin
              rel_pick = (in_chan.ch == dlsc_pkg::CH_EQ) ? dlsc_pkg::REL_GE :
                         (in_chan.ch == dlsc_pkg::CH_GT) ? dlsc_pkg::REL_GT :
                                                           dlsc_pkg::REL_ANY;
            end
            if (rel_pick == dlsc_pkg::REL_ANY) begin
              err = dlsc_pkg::ERR_REL_EXP;
            end else begin
              rel_nxt   = rel_pick;
              ang_nxt   = dlsc_pkg::ANG_NONE;
              phase_nxt = dlsc_pkg::PH_VERS_PRE;
              cls       = dlsc_pkg::CLS_REL;
            end
          end
        end
        dlsc_pkg::PH_VERS_PRE, dlsc_pkg::PH_VERS: begin
          if (sp) begin
            if (phase_r == dlsc_pkg::PH_VERS) begin
              tss_nxt = 1'b1;
            end
          end else if (in_chan.ch == dlsc_pkg::CH_RPAR) begin
            phase_nxt = dlsc_pkg::PH_CLOSED;
            tss_nxt   = 1'b0;
          end else if (dl || (phase_r == dlsc_pkg::PH_VERS && tss_r)) begin
            err = dlsc_pkg::ERR_CLOSE_EXP;
          end else begin
            phase_nxt = dlsc_pkg::PH_VERS;
            tss_nxt   = 1'b0;
            cls       = dlsc_pkg::CLS_VERSION;
          end
        end
        default: begin
          if (sp) begin
            tss_nxt = 1'b1;
          end else if (dl) begin
            cls = dlsc_pkg::CLS_DELIM;
          end else begin
            err = dlsc_pkg::ERR_END_EXP;
          end
        end
      endcase

      if (err != dlsc_pkg::ERR_NONE) begin
        err_nxt     = err;
        res_err_nxt = err;
      end else begin
        if (cls == dlsc_pkg::CLS_DELIM) begin
          phase_nxt = (in_chan.ch == dlsc_pkg::CH_COMMA) ? dlsc_pkg::PH_AFTER_COMMA
                                                         : dlsc_pkg::PH_AFTER_PIPE;
          tss_nxt   = 1'b0;
          ang_nxt   = dlsc_pkg::ANG_NONE;
        end
        cls_nxt     = cls;
        ds_nxt      = ds;
        gs_nxt      = gs;
        res_rel_nxt = rel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dlsc_pkg::PH_LIST_START;
      err_r       <= dlsc_pkg::ERR_NONE;
      rel_r       <= dlsc_pkg::REL_ANY;
      ang_r       <= dlsc_pkg::ANG_NONE;
      tss_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
        rel_r   <= rel_nxt;
        ang_r   <= ang_nxt;
        tss_r   <= tss_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_chan.valid;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r     <= cls_nxt;
      ds_r      <= ds_nxt;
      gs_r      <= gs_nxt;
      res_rel_r <= res_rel_nxt;
      res_err_r <= res_err_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule
